// ===== src/fdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtp_pkg: shared definitions for the structure block token parser
// Token values, word classes, result event codes and the types that travel
// between the classifier, the queue and the execution stage.
// ----------------------------------------------------------------------------
package fdtp_pkg;

   localparam int MAX_DEPTH  = 64;
   localparam int NEST_W     = $clog2(MAX_DEPTH + 1);
   localparam int DEPTH_W    = 7;
   localparam int WORD_W     = 32;
   localparam int EVENT_W    = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

   localparam logic [WORD_W-1:0] TOK_BEGIN   = 32'h0000_0001;
   localparam logic [WORD_W-1:0] TOK_ENDNODE = 32'h0000_0002;
   localparam logic [WORD_W-1:0] TOK_PROP    = 32'h0000_0003;
   localparam logic [WORD_W-1:0] TOK_NOP     = 32'h0000_0004;
   localparam logic [WORD_W-1:0] TOK_END     = 32'h0000_0009;

   localparam logic [2:0] KIND_BEGIN   = 3'd0;
   localparam logic [2:0] KIND_ENDNODE = 3'd1;
   localparam logic [2:0] KIND_PROP    = 3'd2;
   localparam logic [2:0] KIND_NOP     = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;
   localparam logic [2:0] KIND_OTHER   = 3'd5;

   localparam logic [EVENT_W-1:0] EV_BEGIN     = 4'd0;
   localparam logic [EVENT_W-1:0] EV_ENDNODE   = 4'd1;
   localparam logic [EVENT_W-1:0] EV_PROP      = 4'd2;
   localparam logic [EVENT_W-1:0] EV_NOP       = 4'd3;
   localparam logic [EVENT_W-1:0] EV_END       = 4'd4;
   localparam logic [EVENT_W-1:0] EV_NAME      = 4'd5;
   localparam logic [EVENT_W-1:0] EV_LENWORD   = 4'd6;
   localparam logic [EVENT_W-1:0] EV_DATA      = 4'd7;
   localparam logic [EVENT_W-1:0] EV_BADTOKEN  = 4'd8;
   localparam logic [EVENT_W-1:0] EV_IGNORED   = 4'd9;
   localparam logic [EVENT_W-1:0] EV_UNDERFLOW = 4'd10;
   localparam logic [EVENT_W-1:0] EV_OVERFLOW  = 4'd11;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [2:0]        kind;
      logic              zero_byte;
   } fdtp_item_type;

endpackage

// ===== src/fdtp_front.sv =====
// ----------------------------------------------------------------------------
// fdtp_front: word classifier
// Registers each incoming word together with its token class and a flag
// that marks a word holding a zero byte.
// ----------------------------------------------------------------------------
module fdtp_front import fdtp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [31:0]   in_word,
   output logic          out_valid,
   input  logic          out_ready,
   output fdtp_item_type out_item
);

   logic          valid_ff, valid_in;
   fdtp_item_type item_ff, item_in;
   logic          load;

   always_comb begin
      item_in.word = in_word;
      item_in.zero_byte = (in_word[31:24] == 8'h00) || (in_word[23:16] == 8'h00) ||
                          (in_word[15:8] == 8'h00) || (in_word[7:0] == 8'h00);
      priority if (in_word == TOK_BEGIN) begin
         item_in.kind = KIND_BEGIN;
      end else if (in_word == TOK_ENDNODE) begin
         item_in.kind = KIND_ENDNODE;
      end else if (in_word == TOK_PROP) begin
         item_in.kind = KIND_PROP;
      end else if (in_word == TOK_NOP) begin
         item_in.kind = KIND_NOP;
      end else if (in_word == TOK_END) begin
         item_in.kind = KIND_END;
      end else begin
         item_in.kind = KIND_OTHER;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/fdtp_queue.sv =====
// ----------------------------------------------------------------------------
// fdtp_queue: short queue between classifier and execution stage
// A two-entry first-in first-out buffer of classified words.
// ----------------------------------------------------------------------------
module fdtp_queue import fdtp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  fdtp_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output fdtp_item_type pop_item
);

   fdtp_item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic                     push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/fdtp_back.sv =====
// ----------------------------------------------------------------------------
// fdtp_back: parse state and result register
// Applies each classified word to the parse phase, nesting depth and
// property byte count, and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module fdtp_back import fdtp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fdtp_item_type      in_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [EVENT_W-1:0] rsp_event,
   output logic [DEPTH_W-1:0] rsp_depth,
   output logic [WORD_W-1:0]  rsp_prop_length,
   output logic [WORD_W-1:0]  rsp_name_offset,
   output logic [WORD_W-1:0]  rsp_data_value,
   output logic               rsp_finished
);

   localparam logic [2:0] PH_TOKEN   = 3'd0;
   localparam logic [2:0] PH_NAME    = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_NAMEOFF = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   logic [2:0]         phase_ff, phase_in;
   logic [NEST_W-1:0]  nest_ff, nest_in;
   logic [WORD_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [WORD_W-1:0]  held_length_ff, held_length_in;
   logic               valid_ff, valid_in;
   logic [EVENT_W-1:0] event_ff, event_in;
   logic [DEPTH_W-1:0] depth_ff;
   logic [WORD_W-1:0]  plen_ff, plen_in;
   logic [WORD_W-1:0]  noff_ff, noff_in;
   logic [WORD_W-1:0]  dval_ff, dval_in;
   logic               finished_ff;
   logic               take;

   always_comb begin
      phase_in       = phase_ff;
      nest_in        = nest_ff;
      bytes_left_in  = bytes_left_ff;
      held_length_in = held_length_ff;
      event_in       = EV_IGNORED;
      plen_in        = '0;
      noff_in        = '0;
      dval_in        = '0;
      unique case (phase_ff)
         PH_NAME: begin
            event_in = EV_NAME;
            dval_in  = in_item.word;
            if (in_item.zero_byte) begin
               phase_in = PH_TOKEN;
            end
         end
         PH_LEN: begin
            event_in       = EV_LENWORD;
            plen_in        = in_item.word;
            held_length_in = in_item.word;
            phase_in       = PH_NAMEOFF;
         end
         PH_NAMEOFF: begin
            event_in      = EV_PROP;
            plen_in       = held_length_ff;
            noff_in       = in_item.word;
            bytes_left_in = held_length_ff;
            phase_in      = (held_length_ff == '0) ? PH_TOKEN : PH_DATA;
         end
         PH_DATA: begin
            event_in = EV_DATA;
            dval_in  = in_item.word;
            if (bytes_left_ff > WORD_BYTES) begin
               bytes_left_in = bytes_left_ff - WORD_BYTES;
            end else begin
               bytes_left_in = '0;
               phase_in      = PH_TOKEN;
            end
         end
         PH_DONE: begin
            event_in = EV_IGNORED;
         end
         default: begin
            phase_in = PH_TOKEN;
            unique case (in_item.kind)
               KIND_BEGIN: begin
                  phase_in = PH_NAME;
                  if (nest_ff >= NEST_W'(MAX_DEPTH)) begin
                     nest_in  = NEST_W'(MAX_DEPTH);
                     event_in = EV_OVERFLOW;
                  end else begin
                     nest_in  = nest_ff + NEST_W'(1);
                     event_in = EV_BEGIN;
                  end
               end
               KIND_ENDNODE: begin
                  if (nest_ff == '0) begin
                     event_in = EV_UNDERFLOW;
                  end else begin
                     nest_in  = nest_ff - NEST_W'(1);
                     event_in = EV_ENDNODE;
                  end
               end
               KIND_PROP: begin
                  event_in = EV_LENWORD;
                  phase_in = PH_LEN;
               end
               KIND_NOP: begin
                  event_in = EV_NOP;
               end
               KIND_END: begin
                  event_in = EV_END;
                  phase_in = PH_DONE;
               end
               default: begin
                  event_in = EV_BADTOKEN;
               end
            endcase
         end
      endcase
   end

   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign valid_in = take || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         phase_ff       <= PH_TOKEN;
         nest_ff        <= '0;
         bytes_left_ff  <= '0;
         held_length_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            phase_ff       <= phase_in;
            nest_ff        <= nest_in;
            bytes_left_ff  <= bytes_left_in;
            held_length_ff <= held_length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         event_ff    <= event_in;
         depth_ff    <= DEPTH_W'(nest_in);
         plen_ff     <= plen_in;
         noff_ff     <= noff_in;
         dval_ff     <= dval_in;
         finished_ff <= (phase_in == PH_DONE);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event       = event_ff;
   assign rsp_depth       = depth_ff;
   assign rsp_prop_length = plen_ff;
   assign rsp_name_offset = noff_ff;
   assign rsp_data_value  = dval_ff;
   assign rsp_finished    = finished_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      nest_ff <= NEST_W'(MAX_DEPTH))
      else $error("nesting level exceeds the maximum depth");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("parser left the done phase");

   a_data_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("data phase with no bytes left");

   a_finished_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_event == EV_END || rsp_event == EV_IGNORED)
      else $error("finished flag on a result that is neither end nor ignored");

endmodule

// ===== src/fdt_struct_token_parser_top.sv =====
// ----------------------------------------------------------------------------
// fdt_struct_token_parser_top: device tree structure block token parser
// Classifies each 32-bit structure block word and reports one result per
// word with the event, the nesting depth and the property fields.
//
//   Channel  Direction  Payload
//   req_*    in         tdata[31:0] word
//   rsp_*    out        tuser[3:0] event_res; tdata depth, prop_length,
//                       name_offset, data_value, finished
//
// One word is accepted and one result leaves per cycle while the result side is ready.
// A result passes the classifier register and the queue, then waits in the result
// register of the execution stage until it is taken.
// Reset clears the parse phase, depth and byte counters and empties the queue.
// A stall on the result side fills the queue, then holds req_tready low.
// ----------------------------------------------------------------------------
module fdt_struct_token_parser_top import fdtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [6:0] depth, [38:7] prop_length,
                                     // [70:39] name_offset, [102:71] data_value,
                                     // [103] finished
   output logic [3:0]   rsp_tuser    // [3:0] event_res
);

   logic          front_valid, front_ready;
   fdtp_item_type front_item;
   logic          queue_valid, queue_ready;
   fdtp_item_type queue_item;
   logic [DEPTH_W-1:0] depth;
   logic [WORD_W-1:0]  prop_length, name_offset, data_value;
   logic               finished;

   fdtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (req_tdata),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   fdtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   fdtp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (queue_valid),
      .in_ready        (queue_ready),
      .in_item         (queue_item),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_event       (rsp_tuser),
      .rsp_depth       (depth),
      .rsp_prop_length (prop_length),
      .rsp_name_offset (name_offset),
      .rsp_data_value  (data_value),
      .rsp_finished    (finished)
   );

   assign rsp_tdata = {finished, data_value, name_offset, prop_length, depth};

endmodule

// ===== dv/fdt_struct_token_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// fdt_struct_token_parser_top_tb: self-checking bench for the token parser
// Streams structure block words into the parser and predicts the event,
// depth, property fields and done flag of every word. Each result is checked
// in order against the prediction. The stimulus runs from directed corner
// cases through random well-formed node and property sequences mixed with
// noise, then a nesting run to the depth limit and back below zero, and
// finally the end token followed by words the parser must ignore. Both
// sides stall at random, and the result side holds off long enough that the
// parser backs up into its input.
// ----------------------------------------------------------------------------
module fdt_struct_token_parser_top_tb import fdtp_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      WAIT_TOKEN, IN_NAME, IN_LENGTH, IN_NAMEOFF, IN_VALUE, STREAM_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [EVENT_W-1:0] ev;
      logic [DEPTH_W-1:0] depth;
      logic [31:0]        prop_length;
      logic [31:0]        name_offset;
      logic [31:0]        data_value;
      logic               finished;
   } parse_event_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 64;
   localparam int DRAIN_CYCLES   = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;       // [31:0] word
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;            // [6:0] depth, [38:7] prop_length,
                                       // [70:39] name_offset, [102:71] data_value,
                                       // [103] finished
   logic [3:0]   rsp_tuser;            // [3:0] event_res

   logic [31:0]     pending_words[$];
   parse_event_type expected_events[$];

   parse_phase_type tree_phase = WAIT_TOKEN;
   logic [7:0]   tree_depth = '0;
   logic [31:0]  value_bytes_left = '0;
   logic [31:0]  latched_length = '0;

   int           send_idle = 0;
   int           rsp_idle = 0;
   int           gen_depth = 0;
   int           words_accepted = 0;
   int           results_checked = 0;
   int           mismatches = 0;
   int           deepest = 0;
   int           hold_left = 0;
   int           taken_results = 0;
   int           quiet_cycles = 0;
   logic [11:0]  events_seen = '0;

   fdt_struct_token_parser_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic parse_event_type parse_word(logic [31:0] w);
      parse_event_type r;
      r = '0;
      r.ev = EV_IGNORED;
      case (tree_phase)
         IN_NAME: begin
            r.ev = EV_NAME;
            r.data_value = w;
            if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                w[15:8] == 8'h00 || w[7:0] == 8'h00) begin
               tree_phase = WAIT_TOKEN;
            end
         end
         IN_LENGTH: begin
            r.ev = EV_LENWORD;
            r.prop_length = w;
            latched_length = w;
            tree_phase = IN_NAMEOFF;
         end
         IN_NAMEOFF: begin
            r.ev = EV_PROP;
            r.prop_length = latched_length;
            r.name_offset = w;
            value_bytes_left = latched_length;
            tree_phase = (latched_length == 0) ? WAIT_TOKEN : IN_VALUE;
         end
         IN_VALUE: begin
            r.ev = EV_DATA;
            r.data_value = w;
            value_bytes_left = (value_bytes_left > WORD_BYTES) ?
                               value_bytes_left - WORD_BYTES : '0;
            if (value_bytes_left == 0) begin
               tree_phase = WAIT_TOKEN;
            end
         end
         STREAM_DONE: begin
            r.ev = EV_IGNORED;
         end
         default: begin
            tree_phase = WAIT_TOKEN;
            if (w == TOK_BEGIN) begin
               if (tree_depth >= MAX_DEPTH) begin
                  tree_depth = 8'(MAX_DEPTH);
                  r.ev = EV_OVERFLOW;
               end else begin
                  tree_depth = tree_depth + 8'd1;
                  r.ev = EV_BEGIN;
               end
               tree_phase = IN_NAME;
            end else if (w == TOK_ENDNODE) begin
               if (tree_depth == 0) begin
                  r.ev = EV_UNDERFLOW;
               end else begin
                  tree_depth = tree_depth - 8'd1;
                  r.ev = EV_ENDNODE;
               end
            end else if (w == TOK_PROP) begin
               r.ev = EV_LENWORD;
               tree_phase = IN_LENGTH;
            end else if (w == TOK_NOP) begin
               r.ev = EV_NOP;
            end else if (w == TOK_END) begin
               r.ev = EV_END;
               tree_phase = STREAM_DONE;
            end else begin
               r.ev = EV_BADTOKEN;
            end
         end
      endcase
      r.depth = tree_depth[DEPTH_W-1:0];
      r.finished = (tree_phase == STREAM_DONE);
      return r;
   endfunction

   // Stimulus builders. The generator keeps a rough depth of its own only to
   // shape the stream; the prediction never depends on it.
   function automatic logic [31:0] nonzero_bytes();
      return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
   endfunction

   task automatic open_node();
      int         name_words;
      logic [31:0] w;
      pending_words.push_back(TOK_BEGIN);
      if (gen_depth < MAX_DEPTH) begin
         gen_depth++;
      end
      name_words = $urandom_range(1, 3);
      for (int i = 1; i < name_words; i++) begin
         pending_words.push_back(nonzero_bytes());
      end
      if ($urandom_range(9) == 0) begin
         w = '0;
      end else begin
         w = nonzero_bytes();
         w[8*$urandom_range(0, 3) +: 8] = 8'h00;
      end
      pending_words.push_back(w);
   endtask

   task automatic close_node();
      pending_words.push_back(TOK_ENDNODE);
      if (gen_depth > 0) begin
         gen_depth--;
      end
   endtask

   task automatic add_property(logic [31:0] len);
      pending_words.push_back(TOK_PROP);
      pending_words.push_back(len);
      pending_words.push_back($urandom);
      for (int i = 0; i < (len + 3) / 4; i++) begin
         pending_words.push_back($urandom);
      end
   endtask

   task automatic add_random_stream(int count);
      int          goal;
      int          pick;
      logic [31:0] noise;
      goal = pending_words.size() + count;
      while (pending_words.size() < goal) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            open_node();
         end else if (pick < 45) begin
            if (gen_depth > 0 || $urandom_range(3) == 0) begin
               close_node();
            end
         end else if (pick < 78) begin
            if ($urandom_range(9) == 0) begin
               add_property($urandom_range(21, 64));
            end else begin
               add_property($urandom_range(0, 20));
            end
         end else if (pick < 88) begin
            pending_words.push_back(TOK_NOP);
         end else if (pick < 94) begin
            pending_words.push_back($urandom);
         end else begin
            noise = 32'($urandom_range(1, 15)) | (32'h1 << $urandom_range(4, 31));
            pending_words.push_back(noise);
         end
      end
   endtask

   task automatic wait_until_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_events.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Offer the next word at random whenever the current one has gone or none is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_tdata <= pending_words.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side ready at random, with a long hold-off after each of two set numbers of results.
   always @(posedge clock) begin : rsp_side
      int next_hold;
      next_hold = hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         taken_results <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            taken_results <= taken_results + 1;
            if (taken_results + 1 == 60 || taken_results + 1 == 160) begin
               next_hold = LONG_HOLD;
            end
         end else if (next_hold != 0) begin
            next_hold = next_hold - 1;
         end
         hold_left <= next_hold;
         rsp_tready <= (next_hold == 0) && ($urandom_range(99) >= rsp_idle);
      end
   end

   always @(posedge clock) begin : result_check
      parse_event_type got;
      parse_event_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_events.push_back(parse_word(req_tdata));
            words_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ev = rsp_tuser;
            got.depth = rsp_tdata[6:0];
            got.prop_length = rsp_tdata[38:7];
            got.name_offset = rsp_tdata[70:39];
            got.data_value = rsp_tdata[102:71];
            got.finished = rsp_tdata[103];
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: result with no word pending: event %0d depth %0d",
                           got.ev, got.depth);
               end
            end else begin
               want = expected_events.pop_front();
               results_checked++;
               if (got.ev < 12) begin
                  events_seen[got.ev] = 1'b1;
               end
               if (got.depth > deepest) begin
                  deepest = got.depth;
               end
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: result %0d expected ev=%0d depth=%0d len=%h off=%h data=%h fin=%b",
                              results_checked, want.ev, want.depth, want.prop_length,
                              want.name_offset, want.data_value, want.finished);
                     $display("       actual        ev=%0d depth=%0d len=%h off=%h data=%h fin=%b",
                              got.ev, got.depth, got.prop_length, got.name_offset,
                              got.data_value, got.finished);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle = 34;
      rsp_idle = 59;

      // Directed corner cases: name termination in the low byte and the two high bytes, empty and
      // padded properties, unknown tokens and closing below the root.
      pending_words.push_back(TOK_BEGIN);
      pending_words.push_back(32'h4142_4300);
      pending_words.push_back(TOK_BEGIN);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'hFF00_FFFF);
      pending_words.push_back(TOK_BEGIN);
      pending_words.push_back(32'h00FF_FFFF);
      pending_words.push_back(TOK_PROP);
      pending_words.push_back(32'h0000_0000);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(TOK_PROP);
      pending_words.push_back(32'h0000_0005);
      pending_words.push_back(32'h0000_0000);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'h0000_0000);
      pending_words.push_back(TOK_NOP);
      pending_words.push_back(32'h0000_0000);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'h0000_0005);
      pending_words.push_back(TOK_ENDNODE);
      pending_words.push_back(TOK_ENDNODE);
      pending_words.push_back(TOK_ENDNODE);
      pending_words.push_back(TOK_ENDNODE);
      pending_words.push_back(TOK_BEGIN);
      pending_words.push_back(32'hFFFF_FF00);
      gen_depth = 1;

      add_random_stream(60);

      // Wait until every word is sent and every result is back.
      wait_until_drained();

      send_idle = 59;
      rsp_idle = 34;
      add_random_stream(60);
      wait_until_drained();

      send_idle = 0;
      rsp_idle = 0;
      add_random_stream(40);

      // Nest past the depth limit, then unwind one level below the root.
      for (int i = 0; i < MAX_DEPTH + 2; i++) begin
         open_node();
      end
      for (int i = 0; i < MAX_DEPTH + 1; i++) begin
         close_node();
      end

      pending_words.push_back(TOK_END);
      pending_words.push_back(TOK_BEGIN);
      pending_words.push_back(TOK_END);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back($urandom);
      pending_words.push_back(32'h0000_0000);

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d words sent, %0d results checked, %0d mismatches",
               words_accepted, results_checked, mismatches);
      $display("summary: %0d of 12 event kinds seen, deepest nesting %0d",
               $countones(events_seen), deepest);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
